FILE: src/brf_pkg.sv
// shared types, constants and operation codes of the byte ring fifo
`default_nettype none
package brf_pkg;

   localparam int DEPTH_DEF = 256;
   localparam int LANES_DEF = 8;

   localparam int KIND_W = 3;
   localparam int LEN_W  = 4;
   localparam int DATA_W = 64;
   localparam int CAP_W  = 9;
   localparam int OVF_W  = 32;
   localparam int ADDR_W = 3;
   localparam int BUS_W  = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SKIP   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RSTOVF = 3'd5;
   localparam logic [KIND_W-1:0] KIND_STATUS = 3'd6;

   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  length;
      logic [DATA_W-1:0] in_data;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]  moved;
      logic [DATA_W-1:0] out_data;
      logic [CAP_W-1:0]  level;
      logic [CAP_W-1:0]  space_left;
      logic [OVF_W-1:0]  overflow_total;
      logic              is_empty;
      logic              is_full;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic             re;
      logic [LEN_W-1:0] count;
      logic [LEN_W-1:0] offset;
   } lane_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] pos;
      logic [7:0] data;
   } lane_rd_type;

endpackage
`default_nettype wire

FILE: src/brf_lane.sv
// one storage bank: per-bank address, byte select and registered read
`default_nettype none
module brf_lane #(
   parameter int BANK = 0,
   parameter int NB   = 8,
   parameter int ROWS = 32,
   parameter int PW   = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire brf_pkg::lane_ctrl_type ctrl,
   input  wire logic [PW-1:0]        base,
   input  wire logic [63:0]          wdata,
   output brf_pkg::lane_rd_type      rd
);
   import brf_pkg::*;

   localparam int LB  = $clog2(NB);
   localparam int RWW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SW  = PW + 5;

   logic [7:0]       mem [ROWS];
   logic [SW-1:0]    kdiff;
   logic [SW-1:0]    sum;
   logic [LEN_W-1:0] k;
   logic [LEN_W-1:0] pos;
   logic [RWW-1:0]   row;
   logic             en;
   logic [7:0]       wbyte;

   logic             valid_ff, valid_in;
   logic [2:0]       pos_ff;
   logic [7:0]       data_ff;

   always_comb begin
      kdiff = SW'(BANK) - SW'(base);
      k     = LEN_W'(kdiff & SW'(NB - 1));
      sum   = SW'(base) + SW'(k);
      row   = RWW'(sum >> LB);
      en    = (k < ctrl.count);
      pos   = ctrl.offset + k;
      wbyte = wdata[{pos[2:0], 3'b000} +: 8];
      valid_in = ctrl.re && en;
   end

   always_ff @(posedge clock) begin
      if (ctrl.we && en) begin
         mem[row] <= wbyte;
      end
      if (valid_in) begin
         data_ff <= mem[row];
      end
      pos_ff <= pos[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd.valid = valid_ff;
   assign rd.pos   = pos_ff;
   assign rd.data  = data_ff;

endmodule
`default_nettype wire

FILE: src/brf_merge.sv
// merge stage: places the bank read bytes into item order and accumulates segments
`default_nettype none
module brf_merge #(
   parameter int NB = 8
) (
   input  wire logic                        clock,
   input  wire logic                        clear,
   input  wire brf_pkg::lane_rd_type [NB-1:0] rd,
   output logic [63:0]                      merged
);
   import brf_pkg::*;

   logic [63:0] acc_ff, acc_in;

   always_comb begin
      merged = acc_ff;
      for (int b = 0; b < NB; b++) begin
         if (rd[b].valid) begin
            merged[{rd[b].pos, 3'b000} +: 8] = rd[b].data;
         end
      end
      acc_in = clear ? '0 : merged;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

FILE: src/byte_ring_fifo_burst_top.sv
// byte ring fifo top: command sequencer, pointers, config register and banks
// sequence: an item goes through plan, the first segment, a second segment when the burst wraps,
// drain and the result register; no new item is taken while busy, and a wrapping burst
// needs a second bank access
// status, clear and items that move no bytes go from plan straight to drain
// reset: pointers, level and overflow count clear, capacity goes to 256; storage is kept
`default_nettype none
module byte_ring_fifo_burst_top #(
   parameter int DEPTH = brf_pkg::DEPTH_DEF,
   parameter int LANES = brf_pkg::LANES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire brf_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output brf_pkg::rsp_type      rsp_item,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [brf_pkg::ADDR_W-1:0] paddr,
   input  wire logic [brf_pkg::BUS_W-1:0]  pwdata,
   output logic [brf_pkg::BUS_W-1:0]       prdata,
   output logic                  pready
);
   import brf_pkg::*;

   localparam int MAXCAP = (DEPTH < 511) ? DEPTH : 511;
   localparam int PW     = $clog2(MAXCAP);
   localparam int NB     = (LANES <= 1) ? 1 : (LANES <= 2) ? 2 : (LANES <= 4) ? 4 : 8;
   localparam int ROWS   = (DEPTH + NB - 1) / NB;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PLAN, ST_SEG1, ST_SEG2, ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [PW-1:0]     base_ff, base_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [LEN_W-1:0]  s1_ff, s1_in;
   logic [LEN_W-1:0]  s2_ff, s2_in;
   logic [PW-1:0]     wp_ff, wp_in;
   logic [PW-1:0]     rp_ff, rp_in;
   logic [CAP_W-1:0]  held_ff, held_in;
   logic [OVF_W-1:0]  ovf_ff, ovf_in;
   logic [CAP_W-1:0]  capreg_ff, capreg_in;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   logic [CAP_W-1:0]  cap;
   logic [CAP_W-1:0]  room;
   logic [CAP_W-1:0]  avail;
   logic [CAP_W-1:0]  len9;
   logic [CAP_W-1:0]  n9;
   logic [CAP_W-1:0]  base9;
   logic [CAP_W-1:0]  tail;
   logic [CAP_W-1:0]  s19;
   logic [CAP_W:0]    nx;
   logic [CAP_W:0]    nxt;
   logic              is_write, is_rd, is_data, rd_out;
   logic              cfg_wr;

   lane_ctrl_type          ctrl;
   logic [PW-1:0]          lane_base;
   lane_rd_type [NB-1:0]   lane_rd;
   logic [63:0]            merged;

   assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_CAPACITY) ? BUS_W'(capreg_ff) : '0;

   always_comb begin
      cap = (capreg_ff == '0) ? CAP_W'(1) :
            ((capreg_ff > CAP_W'(MAXCAP)) ? CAP_W'(MAXCAP) : capreg_ff);
      is_write = (kind_ff == KIND_WRITE);
      is_rd    = (kind_ff == KIND_READ) || (kind_ff == KIND_PEEK) || (kind_ff == KIND_SKIP);
      is_data  = is_write || is_rd;
      rd_out   = (kind_ff == KIND_READ) || (kind_ff == KIND_PEEK);
      room     = cap - held_ff;
      avail    = is_write ? room : held_ff;
      len9     = CAP_W'(len_ff);
      n9       = !is_data ? '0 : ((len9 > avail) ? avail : len9);
      base9    = is_write ? CAP_W'(wp_ff) : CAP_W'(rp_ff);
      tail     = cap - base9;
      s19      = (n9 > tail) ? tail : n9;
      nx       = {1'b0, base9} + {1'b0, n9};
      nxt      = (nx >= {1'b0, cap}) ? (nx - {1'b0, cap}) : nx;
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      len_in    = len_ff;
      data_in   = data_ff;
      base_in   = base_ff;
      n_in      = n_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      held_in   = held_ff;
      ovf_in    = ovf_ff;
      capreg_in = capreg_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      ctrl      = '0;
      lane_base = base_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_item.kind;
               len_in   = (req_item.length > LEN_W'(LANES)) ? LEN_W'(LANES) : req_item.length;
               data_in  = req_item.in_data;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            base_in = PW'(base9);
            n_in    = LEN_W'(n9);
            s1_in   = LEN_W'(s19);
            s2_in   = LEN_W'(n9 - s19);
            case (kind_ff)
               KIND_WRITE: begin
                  if (len_ff != '0 && len9 > room) begin
                     ovf_in = ovf_ff + 1'b1;
                  end
                  wp_in   = PW'(nxt);
                  held_in = held_ff + n9;
               end
               KIND_READ, KIND_SKIP: begin
                  rp_in   = PW'(nxt);
                  held_in = held_ff - n9;
               end
               KIND_CLEAR: begin
                  wp_in   = '0;
                  rp_in   = '0;
                  held_in = '0;
               end
               KIND_RSTOVF: begin
                  ovf_in = '0;
               end
               default: begin
               end
            endcase
            state_in = (n9 != '0) ? ST_SEG1 : ST_DRAIN;
         end
         ST_SEG1: begin
            ctrl.we     = is_write;
            ctrl.re     = rd_out;
            ctrl.count  = s1_ff;
            ctrl.offset = '0;
            lane_base   = base_ff;
            state_in    = (s2_ff != '0) ? ST_SEG2 : ST_DRAIN;
         end
         ST_SEG2: begin
            ctrl.we     = is_write;
            ctrl.re     = rd_out;
            ctrl.count  = s2_ff;
            ctrl.offset = s1_ff;
            lane_base   = '0;
            state_in    = ST_DRAIN;
         end
         ST_DRAIN: begin
            rsp_in.moved          = n_ff;
            rsp_in.out_data       = merged;
            rsp_in.level          = held_ff;
            rsp_in.space_left     = cap - held_ff;
            rsp_in.overflow_total = ovf_ff;
            rsp_in.is_empty       = (held_ff == '0);
            rsp_in.is_full        = (held_ff >= cap);
            strobe_in             = 1'b1;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         capreg_in = pwdata[CAP_W-1:0];
         wp_in     = '0;
         rp_in     = '0;
         held_in   = '0;
         ovf_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wp_ff     <= '0;
         rp_ff     <= '0;
         held_ff   <= '0;
         ovf_ff    <= '0;
         capreg_ff <= CAP_RESET;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         held_ff   <= held_in;
         ovf_ff    <= ovf_in;
         capreg_ff <= capreg_in;
         strobe_ff <= strobe_in;
      end
      kind_ff <= kind_in;
      len_ff  <= len_in;
      data_ff <= data_in;
      base_ff <= base_in;
      n_ff    <= n_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      rsp_ff  <= rsp_in;
   end

   for (genvar b = 0; b < NB; b++) begin : g_lane
      brf_lane #(
         .BANK (b),
         .NB   (NB),
         .ROWS (ROWS),
         .PW   (PW)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .base  (lane_base),
         .wdata (data_ff),
         .rd    (lane_rd[b])
      );
   end

   brf_merge #(
      .NB (NB)
   ) u_merge (
      .clock  (clock),
      .clear  (state_ff == ST_IDLE),
      .rd     (lane_rd),
      .merged (merged)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while an item is in progress");

   a_level_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap)
      else $error("level above capacity");

   a_ptr_cap: assert property (@(posedge clock) disable iff (reset)
      (CAP_W'(wp_ff) < cap) && (CAP_W'(rp_ff) < cap))
      else $error("pointer beyond wrap point");

   a_accept_plan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_PLAN))
      else $error("accepted item did not enter planning");

   a_seg2_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEG2) |-> ((s2_ff != '0) && (s1_ff + s2_ff == n_ff)))
      else $error("wrap segment without bytes");

endmodule
`default_nettype wire

FILE: dv/byte_ring_fifo_burst_top_test.sv
// testbench of the byte ring fifo: random and directed commands checked against a ring model
`default_nettype none
module byte_ring_fifo_burst_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import brf_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam logic [ADDR_W-1:0] CAPACITY_ADDR = ADDR_W'(4 * REG_CAPACITY);
   localparam int DRAIN_CYCLES = 8;
   localparam int ERR_PRINT_MAX = 50;
   localparam int PHASE_ITEMS = 105;
   localparam int NUM_PHASES = 14;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req_item = '0;
   logic                rsp_strobe;
   rsp_type             rsp_item;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [BUS_W-1:0]    pwdata = '0;
   logic [BUS_W-1:0]    prdata;
   logic                pready;

   req_type             cmd_q[$];
   rsp_type             predicted_rsp_q[$];
   logic                took = 1'b0;
   int                  gap_pct = 0;
   int                  err_cnt = 0;

   // ring model state
   logic [7:0]          ring_mem[DEPTH_DEF];
   int                  wr_ptr;
   int                  rd_ptr;
   int                  held;
   logic [OVF_W-1:0]    ovf_count;
   logic [CAP_W-1:0]    cap_reg;

   byte_ring_fifo_burst_top u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic rsp_type ring_step(req_type it);
      rsp_type r;
      int cap;
      int len;
      int room;
      int p;
      r = '0;
      cap = (cap_reg == 0) ? 1 : ((int'(cap_reg) > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg));
      if (held > cap) held = cap;
      len = (int'(it.length) > LANES_DEF) ? LANES_DEF : int'(it.length);
      case (it.kind)
         KIND_WRITE: begin
            if (len != 0) begin
               room = cap - held;
               if (len > room) begin
                  ovf_count = ovf_count + 1;
                  len = room;
               end
               for (int i = 0; i < len; i++) begin
                  ring_mem[wr_ptr] = it.in_data[8*i +: 8];
                  wr_ptr = (wr_ptr + 1 >= cap) ? 0 : wr_ptr + 1;
               end
               held = held + len;
               r.moved = LEN_W'(len);
            end
         end
         KIND_READ, KIND_PEEK, KIND_SKIP: begin
            p = rd_ptr;
            if (len > held) len = held;
            for (int i = 0; i < len; i++) begin
               if (it.kind != KIND_SKIP) r.out_data[8*i +: 8] = ring_mem[p];
               p = (p + 1 >= cap) ? 0 : p + 1;
            end
            if (it.kind != KIND_PEEK) begin
               rd_ptr = p;
               held = held - len;
            end
            r.moved = LEN_W'(len);
         end
         KIND_CLEAR: begin
            wr_ptr = 0;
            rd_ptr = 0;
            held = 0;
         end
         KIND_RSTOVF: ovf_count = '0;
         default: ;
      endcase
      r.level = CAP_W'(held);
      r.space_left = CAP_W'(cap - held);
      r.overflow_total = ovf_count;
      r.is_empty = (held == 0);
      r.is_full = (held >= cap);
      return r;
   endfunction

   task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         err_cnt++;
         if (err_cnt <= ERR_PRINT_MAX)
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      end
   endtask

   // prediction and result checking
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wr_ptr = 0;
         rd_ptr = 0;
         held = 0;
         ovf_count = '0;
         cap_reg = CAP_RESET;
         took <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (predicted_rsp_q.size() == 0) begin
               err_cnt++;
               if (err_cnt <= ERR_PRINT_MAX)
                  $display("%0t: unexpected result, expected none actual %0h", $time, rsp_item);
            end else begin
               want = predicted_rsp_q.pop_front();
               check_field("moved", 64'(want.moved), 64'(rsp_item.moved));
               check_field("out_data", want.out_data, rsp_item.out_data);
               check_field("level", 64'(want.level), 64'(rsp_item.level));
               check_field("space_left", 64'(want.space_left), 64'(rsp_item.space_left));
               check_field("overflow_total", 64'(want.overflow_total),
                           64'(rsp_item.overflow_total));
               check_field("is_empty", 64'(want.is_empty), 64'(rsp_item.is_empty));
               check_field("is_full", 64'(want.is_full), 64'(rsp_item.is_full));
            end
         end
         if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR) begin
            cap_reg = pwdata[CAP_W-1:0];
            wr_ptr = 0;
            rd_ptr = 0;
            held = 0;
            ovf_count = '0;
         end
         if (start && !busy) predicted_rsp_q.push_back(ring_step(req_item));
         took <= start && !busy;
      end
   end

   // command driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took) begin
         start <= 1'b1;
      end else if (cmd_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
         start <= 1'b1;
         req_item <= cmd_q.pop_front();
      end else begin
         start <= 1'b0;
      end
   end

   function automatic req_type mk_cmd(logic [KIND_W-1:0] k, int len, logic [DATA_W-1:0] d);
      req_type c;
      c.kind = k;
      c.length = LEN_W'(len);
      c.in_data = d;
      return c;
   endfunction

   function automatic req_type rand_cmd(int fill);
      int r;
      int len;
      logic [KIND_W-1:0] k;
      r = $urandom_range(0, 99);
      if (r < 3) k = KIND_CLEAR;
      else if (r < 6) k = KIND_RSTOVF;
      else if (r < 9) k = KIND_STATUS;
      else if (r < 11) k = KIND_UNUSED;
      else if ($urandom_range(0, 99) < fill) k = KIND_WRITE;
      else begin
         case ($urandom_range(0, 3))
            0, 1: k = KIND_READ;
            2: k = KIND_PEEK;
            default: k = KIND_SKIP;
         endcase
      end
      r = $urandom_range(0, 19);
      if (r == 0) len = 0;
      else if (r < 17) len = $urandom_range(1, LANES_DEF);
      else len = $urandom_range(LANES_DEF + 1, 15);
      return mk_cmd(k, len, {$urandom(), $urandom()});
   endfunction

   task automatic wait_idle();
      while (cmd_q.size() != 0 || start || predicted_rsp_q.size() != 0 || busy)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CAP_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CAPACITY_ADDR;
      pwdata <= BUS_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== BUS_W'(value)) begin
         err_cnt++;
         $display("%0t: capacity readback expected %0h actual %0h", $time, value, prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int caps[NUM_PHASES];
      int fill;
      caps = '{1, 0, 2, 256, 9, 17, 511, 100, 3, 255, 300, 8, 64, 256};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty cases, lane extremes, length cut, every operation
      cmd_q.push_back(mk_cmd(KIND_STATUS, 0, '0));
      cmd_q.push_back(mk_cmd(KIND_READ, 4, '0));
      cmd_q.push_back(mk_cmd(KIND_PEEK, 8, '1));
      cmd_q.push_back(mk_cmd(KIND_SKIP, 3, '0));
      cmd_q.push_back(mk_cmd(KIND_WRITE, 0, '1));
      cmd_q.push_back(mk_cmd(KIND_WRITE, 8, '1));
      cmd_q.push_back(mk_cmd(KIND_WRITE, 15, '0));
      cmd_q.push_back(mk_cmd(KIND_WRITE, 8, 64'h5555_aaaa_5555_aaaa));
      cmd_q.push_back(mk_cmd(KIND_WRITE, 8, 64'haaaa_5555_aaaa_5555));
      cmd_q.push_back(mk_cmd(KIND_PEEK, 8, '1));
      cmd_q.push_back(mk_cmd(KIND_READ, 0, '0));
      cmd_q.push_back(mk_cmd(KIND_READ, 3, '1));
      cmd_q.push_back(mk_cmd(KIND_SKIP, 2, '1));
      cmd_q.push_back(mk_cmd(KIND_READ, 12, '0));
      cmd_q.push_back(mk_cmd(KIND_PEEK, 15, '0));
      cmd_q.push_back(mk_cmd(KIND_UNUSED, 7, '1));
      cmd_q.push_back(mk_cmd(KIND_RSTOVF, 0, '0));
      cmd_q.push_back(mk_cmd(KIND_CLEAR, 8, '1));
      cmd_q.push_back(mk_cmd(KIND_STATUS, 15, '1));
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         csr_write(CAP_W'(caps[ph]));
         case (ph % 3)
            0: gap_pct = 0;
            1: gap_pct = 74;
            default: gap_pct = 30;
         endcase
         fill = (caps[ph] >= 100) ? 85 : 55;
         for (int n = 0; n < PHASE_ITEMS; n++) cmd_q.push_back(rand_cmd(fill));
         wait_idle();
      end

      if (err_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
